// File: hw/rtl/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the set-associative lookup
// Sizes of the set store, field widths, register map and the structs
// passed between the register file, the bit packer and the way store.
// ----------------------------------------------------------------------------
package sacl_pkg;

    // Store geometry
    localparam int MAX_SETS  = 1024;
    localparam int MAX_WAYS  = 8;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
    localparam int REC_W     = WAY_W;
    localparam int TAG_W     = 64;
    localparam int ADDR_W    = 64;

    // Bit packer: bits handled per step and number of steps
    localparam int PACK_BITS   = 4;
    localparam int PACK_STEPS  = ADDR_W / PACK_BITS;
    localparam int PACK_CNT_W  = $clog2(PACK_STEPS);

    // Configuration port
    localparam int PDATA_W     = 64;
    localparam int PADDR_W     = 5;
    localparam int REG_SEL_LSB = 3;
    localparam int REG_SEL_W   = PADDR_W - REG_SEL_LSB;

    localparam logic [REG_SEL_W-1:0] REG_ADDRESS_WIDTH = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_OFFSET_WIDTH  = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_INDEX_MASK    = 2'd2;
    localparam logic [REG_SEL_W-1:0] REG_WAYS_IN_USE   = 2'd3;

    localparam logic [6:0]  RST_ADDRESS_WIDTH = 7'd32;
    localparam logic [5:0]  RST_OFFSET_WIDTH  = 6'd4;
    localparam logic [63:0] RST_INDEX_MASK    = 64'd4080;
    localparam logic [3:0]  RST_WAYS_IN_USE   = 4'd4;

    typedef struct packed {
        logic [6:0]  address_width;
        logic [5:0]  offset_width;
        logic [63:0] index_mask;
        logic [3:0]  ways_in_use;
    } cfg_t;

    // One row of the set store: age rank and valid bit of each way
    typedef struct packed {
        logic [MAX_WAYS-1:0][REC_W-1:0] rec;
        logic [MAX_WAYS-1:0]            valid;
    } row_t;

    typedef struct packed {
        logic             done;
        logic [SET_W-1:0] set;
        logic [TAG_W-1:0] tag;
    } pack_res_t;

    typedef struct packed {
        logic                 start;
        logic [SET_W-1:0]     set;
        logic [TAG_W-1:0]     tag;
        logic [WAY_CNT_W-1:0] ways;
    } ways_req_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
    } ways_stat_t;

endpackage

// File: hw/rtl/sacl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_cfg: configuration register file
// APB-style slave holding address width, offset width, index mask and
// associativity. Zero wait states; reads return the stored value.
// ----------------------------------------------------------------------------
module sacl_cfg
    import sacl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_SEL_W-1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:REG_SEL_LSB];
    assign cfg     = cfg_reg;

    // Decode the write request
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_ADDRESS_WIDTH: cfg_next.address_width = pwdata[6:0];
                REG_OFFSET_WIDTH:  cfg_next.offset_width  = pwdata[5:0];
                REG_INDEX_MASK:    cfg_next.index_mask    = pwdata[63:0];
                REG_WAYS_IN_USE:   cfg_next.ways_in_use   = pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.address_width <= RST_ADDRESS_WIDTH;
            cfg_reg.offset_width  <= RST_OFFSET_WIDTH;
            cfg_reg.index_mask    <= RST_INDEX_MASK;
            cfg_reg.ways_in_use   <= RST_WAYS_IN_USE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back, zero-extended
    always_comb begin
        case (reg_sel)
            REG_ADDRESS_WIDTH: prdata = PDATA_W'(cfg_reg.address_width);
            REG_OFFSET_WIDTH:  prdata = PDATA_W'(cfg_reg.offset_width);
            REG_INDEX_MASK:    prdata = PDATA_W'(cfg_reg.index_mask);
            REG_WAYS_IN_USE:   prdata = PDATA_W'(cfg_reg.ways_in_use);
            default:           prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/sacl_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pack: iterative set index and tag extractor
// Masks the address, then walks it from the top bit down, a few bits a
// cycle, shifting index-mask bits into the set index and the rest of the
// block address into the tag.
// ----------------------------------------------------------------------------
module sacl_pack
    import sacl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ADDR_W-1:0] address,
    input  cfg_t              cfg,
    output pack_res_t         res
);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [PACK_CNT_W-1:0] cnt_reg;
    logic [PACK_CNT_W-1:0] cnt_next;
    logic [ADDR_W-1:0]     a_reg;
    logic [ADDR_W-1:0]     a_next;
    logic [ADDR_W-1:0]     im_reg;
    logic [ADDR_W-1:0]     im_next;
    logic [ADDR_W-1:0]     tm_reg;
    logic [ADDR_W-1:0]     tm_next;
    logic [SET_W-1:0]      idx_reg;
    logic [SET_W-1:0]      idx_next;
    logic [TAG_W-1:0]      tag_reg;
    logic [TAG_W-1:0]      tag_next;
    logic [SET_W-1:0]      idx_step;
    logic [TAG_W-1:0]      tag_step;
    logic [ADDR_W-1:0]     valid_mask;
    logic [ADDR_W-1:0]     low_mask;
    logic [ADDR_W-1:0]     blk_mask;

    // Masks from the current configuration
    always_comb begin
        if (cfg.address_width >= 7'(ADDR_W)) begin
            valid_mask = '1;
        end else begin
            valid_mask = (ADDR_W'(1) << cfg.address_width) - ADDR_W'(1);
        end
        low_mask = (ADDR_W'(1) << cfg.offset_width) - ADDR_W'(1);
        blk_mask = valid_mask & ~low_mask;
    end

    // Shift the top bits of the window into index or tag
    always_comb begin
        idx_step = idx_reg;
        tag_step = tag_reg;
        for (int j = PACK_BITS - 1; j >= 0; j--) begin
            if (im_reg[ADDR_W-PACK_BITS+j]) begin
                idx_step = {idx_step[SET_W-2:0], a_reg[ADDR_W-PACK_BITS+j]};
            end else if (tm_reg[ADDR_W-PACK_BITS+j]) begin
                tag_step = {tag_step[TAG_W-2:0], a_reg[ADDR_W-PACK_BITS+j]};
            end
        end
    end

    // Load on start, advance one window a cycle while busy
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        im_next   = im_reg;
        tm_next   = tm_reg;
        idx_next  = idx_reg;
        tag_next  = tag_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = address & valid_mask;
            im_next   = cfg.index_mask & blk_mask;
            tm_next   = blk_mask & ~cfg.index_mask;
            idx_next  = '0;
            tag_next  = '0;
        end else if (busy_reg) begin
            a_next   = a_reg << PACK_BITS;
            im_next  = im_reg << PACK_BITS;
            tm_next  = tm_reg << PACK_BITS;
            idx_next = idx_step;
            tag_next = tag_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == PACK_CNT_W'(PACK_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        im_reg  <= im_next;
        tm_reg  <= tm_next;
        idx_reg <= idx_next;
        tag_reg <= tag_next;
    end

    assign res.done = done_reg;
    assign res.set  = idx_reg;
    assign res.tag  = tag_reg;

endmodule

// File: hw/rtl/sacl_ways.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ways: set store and way scanner
// Holds a row per set (valid bits and age ranks) and a tag memory per
// set and way. One shared tag comparator walks the ways of a set, then the
// update state writes back the ages, valid bits and, on a miss, a new tag.
// ----------------------------------------------------------------------------
module sacl_ways
    import sacl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ways_req_t  req,
    output ways_stat_t stat
);

    localparam logic [2:0] W_CLEAR  = 3'd0;
    localparam logic [2:0] W_IDLE   = 3'd1;
    localparam logic [2:0] W_ROW    = 3'd2;
    localparam logic [2:0] W_TAGRD  = 3'd3;
    localparam logic [2:0] W_TAGCMP = 3'd4;
    localparam logic [2:0] W_UPDATE = 3'd5;

    row_t             row_mem [MAX_SETS];
    logic [TAG_W-1:0] tag_mem [MAX_SETS*MAX_WAYS];

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [SET_W-1:0]     clr_idx_reg;
    logic [SET_W-1:0]     clr_idx_next;
    logic                 done_reg;
    logic                 done_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 free_found_reg;
    logic                 free_found_next;
    logic [WAY_W-1:0]     hit_way_reg;
    logic [WAY_W-1:0]     hit_way_next;
    logic [WAY_W-1:0]     free_way_reg;
    logic [WAY_W-1:0]     free_way_next;
    logic [WAY_W-1:0]     old_way_reg;
    logic [WAY_W-1:0]     old_way_next;
    logic [REC_W-1:0]     oldest_reg;
    logic [REC_W-1:0]     oldest_next;
    logic [WAY_CNT_W-1:0] way_reg;
    logic [WAY_CNT_W-1:0] way_next;
    logic [WAY_CNT_W-1:0] ways_reg;
    logic [WAY_CNT_W-1:0] ways_next;
    logic [SET_W-1:0]     set_reg;
    logic [SET_W-1:0]     set_next;
    logic [TAG_W-1:0]     tag_reg;
    logic [TAG_W-1:0]     tag_next;
    row_t                 row_rd_reg;
    logic [TAG_W-1:0]     tag_rd_reg;

    logic [WAY_W-1:0]       cur_way;
    logic                   cur_valid;
    logic [REC_W-1:0]       cur_rec;
    logic                   match;
    logic                   last_way;
    logic [WAY_W-1:0]       tgt_way;
    logic                   is_fill;
    logic [REC_W-1:0]       ref_age;
    row_t                   new_row;
    logic                   row_we;
    logic [SET_W-1:0]       row_waddr;
    row_t                   row_wdata;
    logic                   tag_we;

    // Way under comparison
    assign cur_way   = way_reg[WAY_W-1:0];
    assign cur_valid = row_rd_reg.valid[cur_way];
    assign cur_rec   = row_rd_reg.rec[cur_way];
    assign match     = cur_valid && (tag_rd_reg == tag_reg);
    assign last_way  = (way_reg == ways_reg - 1'b1);

    // Pick the way to refresh: hit, first free way, or oldest
    assign tgt_way = hit_reg ? hit_way_reg : (free_found_reg ? free_way_reg : old_way_reg);
    assign is_fill = !hit_reg && free_found_reg;
    assign ref_age = row_rd_reg.rec[tgt_way];

    // Age every younger valid way by one, make the target the newest
    always_comb begin
        for (int k = 0; k < MAX_WAYS; k++) begin
            new_row.valid[k] = row_rd_reg.valid[k] || (is_fill && (tgt_way == WAY_W'(k)));
            if (tgt_way == WAY_W'(k)) begin
                new_row.rec[k] = '0;
            end else if (row_rd_reg.valid[k] && (is_fill || (row_rd_reg.rec[k] < ref_age))) begin
                new_row.rec[k] = row_rd_reg.rec[k] + 1'b1;
            end else begin
                new_row.rec[k] = row_rd_reg.rec[k];
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        hit_way_next    = hit_way_reg;
        free_way_next   = free_way_reg;
        old_way_next    = old_way_reg;
        oldest_next     = oldest_reg;
        way_next        = way_reg;
        ways_next       = ways_reg;
        set_next        = set_reg;
        tag_next        = tag_reg;
        case (state_reg)
            W_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_W'(MAX_SETS - 1)) begin
                    state_next = W_IDLE;
                end
            end
            W_IDLE: begin
                if (req.start) begin
                    set_next        = req.set;
                    tag_next        = req.tag;
                    ways_next       = req.ways;
                    way_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = W_ROW;
                end
            end
            W_ROW: begin
                state_next = W_TAGRD;
            end
            W_TAGRD: begin
                state_next = W_TAGCMP;
            end
            W_TAGCMP: begin
                if (match) begin
                    hit_next     = 1'b1;
                    hit_way_next = cur_way;
                    state_next   = W_UPDATE;
                end else begin
                    if (!cur_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_way_next   = cur_way;
                    end
                    if ((way_reg == '0) || (cur_rec > oldest_reg)) begin
                        oldest_next  = cur_rec;
                        old_way_next = cur_way;
                    end
                    if (last_way) begin
                        state_next = W_UPDATE;
                    end else begin
                        way_next   = way_reg + 1'b1;
                        state_next = W_TAGRD;
                    end
                end
            end
            W_UPDATE: begin
                done_next  = 1'b1;
                state_next = W_IDLE;
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= W_CLEAR;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg        <= hit_next;
        free_found_reg <= free_found_next;
        hit_way_reg    <= hit_way_next;
        free_way_reg   <= free_way_next;
        old_way_reg    <= old_way_next;
        oldest_reg     <= oldest_next;
        way_reg        <= way_next;
        ways_reg       <= ways_next;
        set_reg        <= set_next;
        tag_reg        <= tag_next;
    end

    // Row store: cleared after reset, written back at the end of a lookup
    assign row_we    = (state_reg == W_CLEAR) || (state_reg == W_UPDATE);
    assign row_waddr = (state_reg == W_CLEAR) ? clr_idx_reg : set_reg;
    assign row_wdata = (state_reg == W_CLEAR) ? row_t'('0) : new_row;

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rd_reg <= row_mem[set_reg];
    end

    // Tag store: new tag on a miss
    assign tag_we = (state_reg == W_UPDATE) && !hit_reg;

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[{set_reg, tgt_way}] <= tag_reg;
        end
        tag_rd_reg <= tag_mem[{set_reg, cur_way}];
    end

    assign stat.ready = (state_reg == W_IDLE);
    assign stat.done  = done_reg;
    assign stat.hit   = hit_reg;

endmodule

// File: hw/rtl/set_assoc_cache_lru_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup: set-associative cache lookup with LRU
// Takes a byte address, extracts set index and tag under a configurable
// mask and reports hit or miss, refilling the set with LRU replacement.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_address[63:0]
//  m_       out        m_valid / m_ready  m_hit, m_set_number[9:0]
//  apb      in/out     psel/penable       paddr[4:0], pwdata/prdata[63:0]
//
// The packer handles 4 address bits a cycle and the single tag comparator
// compares one way at a time through the registered tag memory, up to the
// associativity; a hit stops the scan. After reset the set store is cleared,
// one set a cycle, all 1024 sets; s_ready stays low meanwhile. A result
// waiting on m_ready holds the next request in the final stage; s_ready is
// high only when the block is idle.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup
    import sacl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ADDR_W-1:0]  s_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [SET_W-1:0]   m_set_number
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PACK = 2'd1;
    localparam logic [1:0] ST_LOOK = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    cfg_t       cfg;
    pack_res_t  pack_res;
    ways_req_t  ways_req;
    ways_stat_t ways_stat;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 m_hit_reg;
    logic                 m_hit_next;
    logic [SET_W-1:0]     m_set_reg;
    logic [SET_W-1:0]     m_set_next;
    logic                 hit_hold_reg;
    logic                 hit_hold_next;
    logic                 s_accept;
    logic                 m_load;
    logic [WAY_CNT_W-1:0] ways_eff;

    sacl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sacl_pack u_pack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .address (s_address),
        .cfg     (cfg),
        .res     (pack_res)
    );

    sacl_ways u_ways (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ways_req),
        .stat    (ways_stat)
    );

    assign s_ready  = (state_reg == ST_IDLE) && ways_stat.ready;
    assign s_accept = s_valid && s_ready;

    // Clamp associativity to 1..MAX_WAYS
    always_comb begin
        if (cfg.ways_in_use == '0) begin
            ways_eff = WAY_CNT_W'(1);
        end else if (cfg.ways_in_use > 4'(MAX_WAYS)) begin
            ways_eff = WAY_CNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WAY_CNT_W'(cfg.ways_in_use);
        end
    end

    assign ways_req.start = (state_reg == ST_PACK) && pack_res.done;
    assign ways_req.set   = pack_res.set;
    assign ways_req.tag   = pack_res.tag;
    assign ways_req.ways  = ways_eff;

    // Load the output stage once it is free
    assign m_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        hit_hold_next = hit_hold_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_PACK;
                end
            end
            ST_PACK: begin
                if (pack_res.done) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (ways_stat.done) begin
                    hit_hold_next = ways_stat.hit;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output stage: hold until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_hit_next   = m_hit_reg;
        m_set_next   = m_set_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
            m_hit_next   = hit_hold_reg;
            m_set_next   = pack_res.set;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_hold_reg <= hit_hold_next;
        m_hit_reg    <= m_hit_next;
        m_set_reg    <= m_set_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_set_number = m_set_reg;

endmodule
